>>> design/spsg_pkg.sv
// Shared constants for the servo PWM sweep generator.
package spsg_pkg;

    // Field widths of the stream words.
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned CHAN_W    = 3;
    localparam int unsigned PINS_W    = 8;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // Configuration port geometry.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes within the configuration space.
    typedef enum logic [1:0] {
        REG_PERIOD_TICKS    = 2'd0,
        REG_DUTY_HIGH_LIMIT = 2'd1,
        REG_RAMP_INTERVAL   = 2'd2,
        REG_INITIAL_DUTY    = 2'd3
    } reg_index_t;

    // Input word kinds carried on tuser.
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // Reset values of the registers and state.
    localparam logic [CNT_W-1:0]    PERIOD_TICKS_RST    = 16'd304;
    localparam logic [CNT_W-1:0]    DUTY_HIGH_LIMIT_RST = 16'd304;
    localparam logic [CNT_W-1:0]    RAMP_INTERVAL_RST   = 16'd10000;
    localparam logic [CNT_W-1:0]    INITIAL_DUTY_RST    = 16'd1;
    localparam logic [CNT_W-1:0]    COUNTER_RST         = 16'd1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_RST          = 8'd1;

    // Division of a 16-bit value by 60: multiply by ceil(2^21 / 60), keep bits 31:21.
    // The error stays below one part in 60 for every 16-bit input, so the floor is exact.
    localparam logic [CNT_W-1:0] DIV60_RECIP = 16'd34953;
    localparam int unsigned      DIV60_SHIFT = 21;
    localparam logic [CNT_W-1:0] DUTY_MAX    = 16'hFFFF;

endpackage

>>> design/servo_pwm_sweep_generator_core.sv
// Multi-channel PWM generator with a slow duty ramp that sweeps one channel at a time.
//
//  Channel   Dir  Words                        Fields (low bit first)
//  s_*       in   tick or sample store         tuser: op; tdata: channel, sample
//  m_*       out  one word per tick            tdata: pwm_pins, period_start, ramp_channel
//  APB       in   four 16-bit registers        period_ticks, duty_high_limit,
//                                               ramp_interval, initial_duty
//
// A tick updates the PWM and ramp state in the cycle it is taken and writes its result into the
// output register at the same edge; a store only records its sample. One word per cycle is
// accepted as long as the output register is empty or being drained; a stall on m_* holds
// s_tready low. Sample stores produce no output word. rst_n loads the reset values of the
// registers and counters and clears the pins and the output valid.
// The longest path is the ramp step: a subtract, one 16x16 multiply and a saturating add.
module servo_pwm_sweep_generator_core #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream. tuser: op. tdata: channel [2:0], sample [10:3], zero [15:11].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tuser,
    input  logic [spsg_pkg::IN_DATA_W-1:0]     s_tdata,
    // Output stream. tdata: pwm_pins [7:0], period_start [8], ramp_channel [11:9],
    // zero [15:12].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spsg_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spsg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spsg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spsg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import spsg_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    // Configuration registers.
    logic [CNT_W-1:0] period_ticks_reg;
    logic [CNT_W-1:0] duty_high_limit_reg;
    logic [CNT_W-1:0] ramp_interval_reg;
    logic [CNT_W-1:0] initial_duty_reg;

    // PWM and ramp state.
    logic [CNT_W-1:0]    period_count_reg, period_count_next;
    logic [CNT_W-1:0]    pulse_count_reg [CHANNELS];
    logic [CNT_W-1:0]    pulse_count_next [CHANNELS];
    logic [CNT_W-1:0]    duty_value_reg [CHANNELS];
    logic [CHANNELS-1:0] pin_state_reg, pin_state_next;
    logic [CNT_W-1:0]    ramp_timer_reg, ramp_timer_next;
    logic [IDX_W-1:0]    ramp_index_reg, ramp_index_next;
    logic [SAMPLE_W-1:0] latest_sample_reg [CHANNELS];

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Handshake decode.
    logic             accept;
    logic             tick;
    logic             store;
    logic [CHAN_W-1:0]   in_channel;
    logic [SAMPLE_W-1:0] in_sample;
    logic             chan_ok;
    logic             cfg_write;
    reg_index_t       cfg_index;
    logic             duty_reload;

    // Datapath intermediates.
    logic [CNT_W-1:0]      period_dec;
    logic                  period_start;
    logic [CNT_W-1:0]      ramp_dec;
    logic                  ramp_expire;
    logic [CNT_W-1:0]      sel_duty;
    logic [SAMPLE_W-1:0]   sel_sample;
    logic [CNT_W-1:0]      sample_ext;
    logic [CNT_W-1:0]      ramp_diff;
    logic [2*CNT_W-1:0]    ramp_prod;
    logic [CNT_W-1:0]      ramp_step;
    logic [CNT_W:0]        ramp_sum;
    logic                  at_limit;
    logic [CNT_W-1:0]      new_duty;

    // The input side takes a word whenever the output register can accept a result.
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign tick       = accept && (op_t'(s_tuser) == OP_TICK);
    assign store      = accept && (op_t'(s_tuser) == OP_SAMPLE);
    assign in_channel = s_tdata[CHAN_W-1:0];
    assign in_sample  = s_tdata[CHAN_W +: SAMPLE_W];
    assign chan_ok    = ({1'b0, in_channel} < (CHAN_W + 1)'(CHANNELS));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Register write decode; pready is tied high.
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign cfg_index   = reg_index_t'(paddr[3:2]);
    assign duty_reload = cfg_write && (cfg_index == REG_INITIAL_DUTY);

    // Register read-back.
    always_comb
    begin
        case (cfg_index)
            REG_PERIOD_TICKS:    prdata = APB_DATA_W'(period_ticks_reg);
            REG_DUTY_HIGH_LIMIT: prdata = APB_DATA_W'(duty_high_limit_reg);
            REG_RAMP_INTERVAL:   prdata = APB_DATA_W'(ramp_interval_reg);
            REG_INITIAL_DUTY:    prdata = APB_DATA_W'(initial_duty_reg);
            default:             prdata = '0;
        endcase
    end

    // PWM step: period countdown, then per-channel pulse countdown.
    always_comb
    begin
        period_dec   = period_count_reg - 1'b1;
        period_start = (period_dec == '0);
        if (period_start)
        begin
            period_count_next = period_ticks_reg;
            pin_state_next    = '1;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pulse_count_next[i] = duty_value_reg[i];
            end
        end
        else
        begin
            period_count_next = period_dec;
            pin_state_next    = pin_state_reg;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pulse_count_next[i] = pulse_count_reg[i];
                if (pin_state_reg[i])
                begin
                    pulse_count_next[i] = pulse_count_reg[i] - 1'b1;
                    if (pulse_count_next[i] == '0)
                    begin
                        pin_state_next[i] = 1'b0;
                    end
                end
            end
        end
    end

    // Ramp step on the current channel: restart from the sample or grow by a sixtieth of the span.
    always_comb
    begin
        ramp_dec    = ramp_timer_reg - 1'b1;
        ramp_expire = (ramp_dec == '0);
        sel_duty    = duty_value_reg[ramp_index_reg];
        sel_sample  = latest_sample_reg[ramp_index_reg];
        sample_ext  = CNT_W'(sel_sample);
        ramp_diff   = (duty_high_limit_reg > sample_ext) ? (duty_high_limit_reg - sample_ext) : '0;
        ramp_prod   = ramp_diff * DIV60_RECIP;
        ramp_step   = CNT_W'(ramp_prod[2*CNT_W-1:DIV60_SHIFT]);
        ramp_sum    = {1'b0, sel_duty} + {1'b0, ramp_step};
        at_limit    = (sel_duty >= duty_high_limit_reg);

        ramp_timer_next = ramp_expire ? ramp_interval_reg : ramp_dec;
        ramp_index_next = ramp_index_reg;
        if (at_limit)
        begin
            new_duty = sample_ext;
            if (ramp_expire)
            begin
                ramp_index_next = (ramp_index_reg == LAST_IDX) ? '0 : ramp_index_reg + 1'b1;
            end
        end
        else
        begin
            new_duty = ramp_sum[CNT_W] ? DUTY_MAX : ramp_sum[CNT_W-1:0];
        end
    end

    // Result word for a tick.
    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[PINS_W-1:0]                = PINS_W'(pin_state_next);
        m_tdata_next[PINS_W]                    = period_start;
        m_tdata_next[PINS_W+1 +: CHAN_W]        = CHAN_W'(ramp_index_next);
        if (tick)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Configuration registers and duty values; writing initial_duty reloads every duty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ticks_reg    <= PERIOD_TICKS_RST;
            duty_high_limit_reg <= DUTY_HIGH_LIMIT_RST;
            ramp_interval_reg   <= RAMP_INTERVAL_RST;
            initial_duty_reg    <= INITIAL_DUTY_RST;
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_value_reg[i] <= INITIAL_DUTY_RST;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PERIOD_TICKS:    period_ticks_reg    <= pwdata[CNT_W-1:0];
                    REG_DUTY_HIGH_LIMIT: duty_high_limit_reg <= pwdata[CNT_W-1:0];
                    REG_RAMP_INTERVAL:   ramp_interval_reg   <= pwdata[CNT_W-1:0];
                    REG_INITIAL_DUTY:
                    begin
                        initial_duty_reg <= pwdata[CNT_W-1:0];
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            duty_value_reg[i] <= pwdata[CNT_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            // A duty reload wins over a ramp step; other register writes leave it alone.
            if (tick && ramp_expire && !duty_reload)
            begin
                duty_value_reg[ramp_index_reg] <= new_duty;
            end
        end
    end

    // PWM, ramp and sample state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= COUNTER_RST;
            pin_state_reg    <= '0;
            ramp_timer_reg   <= COUNTER_RST;
            ramp_index_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pulse_count_reg[i]   <= '0;
                latest_sample_reg[i] <= SAMPLE_RST;
            end
        end
        else
        begin
            if (tick)
            begin
                period_count_reg <= period_count_next;
                pin_state_reg    <= pin_state_next;
                ramp_timer_reg   <= ramp_timer_next;
                ramp_index_reg   <= ramp_index_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    pulse_count_reg[i] <= pulse_count_next[i];
                end
            end
            if (store && chan_ok)
            begin
                latest_sample_reg[in_channel[IDX_W-1:0]] <= in_sample;
            end
        end
    end

    // Output register: valid is control, the word itself needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
